>>> hw/rtl/bfcf_pkg.sv
// Shared types and constants for the BCD frequency command framer.
`default_nettype none

package bfcf_pkg;

   // Input word and BCD widths
   localparam int unsigned UNITS_W  = 27;
   localparam int unsigned DIGITS   = 8;
   localparam int unsigned BCD_W    = 4 * DIGITS;
   localparam int unsigned BYTE_W   = 8;

   // Largest frequency that fits in eight decimal digits
   localparam logic [UNITS_W-1:0] MAX_UNITS = 27'd99999999;

   // Frame bytes
   localparam logic [BYTE_W-1:0] PREAMBLE_BYTE = 8'hfe;
   localparam logic [BYTE_W-1:0] CMD_SET_FREQ  = 8'h05;
   localparam logic [BYTE_W-1:0] SUBCMD_BYTE   = 8'h00;
   localparam logic [BYTE_W-1:0] END_BYTE      = 8'hfd;

   // Address register reset values
   localparam logic [BYTE_W-1:0] RADIO_ADDR_RST = 8'h52;
   localparam logic [BYTE_W-1:0] CTRL_ADDR_RST  = 8'he0;

   // Register index codes
   localparam logic REG_RADIO_ADDR = 1'b0;
   localparam logic REG_CTRL_ADDR  = 1'b1;

   // One slot of the conversion chain: remaining binary bits and partial BCD
   typedef struct packed {
      logic               valid;
      logic [UNITS_W-1:0] bin;
      logic [BCD_W-1:0]   bcd;
   } stage_type;

   // True when every nibble holds a decimal digit
   function automatic logic digits_ok(input logic [BCD_W-1:0] bcd);
      logic ok;
      ok = 1'b1;
      for (int i = 0; i < DIGITS; i++) begin
         if (bcd[4*i +: 4] > 4'd9) begin
            ok = 1'b0;
         end
      end
      return ok;
   endfunction

endpackage

`default_nettype wire

>>> hw/rtl/bfcf_dd_cell.sv
// One shift-and-correct cell of the binary to BCD conversion chain.
`default_nettype none

module bfcf_dd_cell (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                advance,
   input  wire bfcf_pkg::stage_type slot_in,
   output bfcf_pkg::stage_type      slot_out
);

   logic                          valid_ff;
   logic                          valid_in;
   logic [bfcf_pkg::UNITS_W-1:0]  bin_ff;
   logic [bfcf_pkg::UNITS_W-1:0]  bin_in;
   logic [bfcf_pkg::BCD_W-1:0]    bcd_ff;
   logic [bfcf_pkg::BCD_W-1:0]    bcd_in;
   logic [bfcf_pkg::BCD_W-1:0]    bcd_fix;

   // Add three to every digit of five or more, then shift one binary bit in
   always_comb begin
      for (int i = 0; i < bfcf_pkg::DIGITS; i++) begin
         if (slot_in.bcd[4*i +: 4] >= 4'd5) begin
            bcd_fix[4*i +: 4] = slot_in.bcd[4*i +: 4] + 4'd3;
         end else begin
            bcd_fix[4*i +: 4] = slot_in.bcd[4*i +: 4];
         end
      end
      bcd_in   = {bcd_fix[bfcf_pkg::BCD_W-2:0], slot_in.bin[bfcf_pkg::UNITS_W-1]};
      bin_in   = {slot_in.bin[bfcf_pkg::UNITS_W-2:0], 1'b0};
      valid_in = slot_in.valid;
   end

   // Hold the valid bit under reset
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= valid_in;
      end
   end

   // Advance the payload with the chain
   always_ff @(posedge clock) begin
      if (advance) begin
         bin_ff <= bin_in;
         bcd_ff <= bcd_in;
      end
   end

   assign slot_out.valid = valid_ff;
   assign slot_out.bin   = bin_ff;
   assign slot_out.bcd   = bcd_ff;

endmodule

`default_nettype wire

>>> hw/rtl/bfcf_framer.sv
// Byte sequencer that sends the eleven-byte set-frequency command.
`default_nettype none

module bfcf_framer (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire bfcf_pkg::stage_type              tail,
   input  wire logic [bfcf_pkg::BYTE_W-1:0]      radio_addr,
   input  wire logic [bfcf_pkg::BYTE_W-1:0]      ctrl_addr,
   output logic                                  load,
   output logic                                  rsp_valid,
   input  wire logic                             rsp_stall,
   output logic [bfcf_pkg::BYTE_W-1:0]           rsp_command_byte,
   output logic                                  rsp_last_byte
);

   // Byte positions in the frame
   localparam logic [3:0] POS_PRE0  = 4'd0;
   localparam logic [3:0] POS_PRE1  = 4'd1;
   localparam logic [3:0] POS_RADIO = 4'd2;
   localparam logic [3:0] POS_CTRL  = 4'd3;
   localparam logic [3:0] POS_CMD   = 4'd4;
   localparam logic [3:0] POS_SUB   = 4'd5;
   localparam logic [3:0] POS_BCD0  = 4'd6;
   localparam logic [3:0] POS_BCD1  = 4'd7;
   localparam logic [3:0] POS_BCD2  = 4'd8;
   localparam logic [3:0] POS_BCD3  = 4'd9;
   localparam logic [3:0] POS_END   = 4'd10;

   logic                         busy_ff;
   logic                         busy_in;
   logic [3:0]                   pos_ff;
   logic [3:0]                   pos_in;
   logic [bfcf_pkg::BCD_W-1:0]   bcd_ff;
   logic                         take;
   logic                         at_end;

   assign take   = busy_ff & ~rsp_stall;
   assign at_end = (pos_ff == POS_END);
   assign load   = tail.valid & (~busy_ff | (take & at_end));

   // Step through the frame, reload on the last word taken
   always_comb begin
      busy_in = busy_ff;
      pos_in  = pos_ff;
      if (load) begin
         busy_in = 1'b1;
         pos_in  = POS_PRE0;
      end else if (take) begin
         if (at_end) begin
            busy_in = 1'b0;
         end else begin
            pos_in = pos_ff + 4'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         pos_ff  <= POS_PRE0;
      end else begin
         busy_ff <= busy_in;
         pos_ff  <= pos_in;
      end
   end

   // Capture the finished digits
   always_ff @(posedge clock) begin
      if (load) begin
         bcd_ff <= tail.bcd;
      end
   end

   // Select the byte at the current position
   always_comb begin
      unique case (pos_ff)
         POS_PRE0:  rsp_command_byte = bfcf_pkg::PREAMBLE_BYTE;
         POS_PRE1:  rsp_command_byte = bfcf_pkg::PREAMBLE_BYTE;
         POS_RADIO: rsp_command_byte = radio_addr;
         POS_CTRL:  rsp_command_byte = ctrl_addr;
         POS_CMD:   rsp_command_byte = bfcf_pkg::CMD_SET_FREQ;
         POS_SUB:   rsp_command_byte = bfcf_pkg::SUBCMD_BYTE;
         POS_BCD0:  rsp_command_byte = bcd_ff[7:0];
         POS_BCD1:  rsp_command_byte = bcd_ff[15:8];
         POS_BCD2:  rsp_command_byte = bcd_ff[23:16];
         POS_BCD3:  rsp_command_byte = bcd_ff[31:24];
         POS_END:   rsp_command_byte = bfcf_pkg::END_BYTE;
         default:   rsp_command_byte = bfcf_pkg::END_BYTE;
      endcase
   end

   assign rsp_valid     = busy_ff;
   assign rsp_last_byte = at_end;

endmodule

`default_nettype wire

>>> hw/rtl/bcd_frequency_command_framer.sv
// Top level: BCD conversion chain, frame sequencer and address registers.
// Path: a word passes through the 27 conversion cells, one per binary bit, and the frame
//   sequencer then loads it and shows its first command byte.
// Flow: the sequencer sends one byte per cycle unless rsp_stall holds it; the chain takes
//   a new word every cycle until a finished word waits at its tail for the current frame to end.
// Reset: synchronous; clears the chain's valid bits and the sequencer, and sets the
//   radio address to 0x52 and the controller address to 0xe0.
`default_nettype none

module bcd_frequency_command_framer (
   input  wire logic                              clock,
   input  wire logic                              reset,
   // Input channel
   input  wire logic                              req_valid,
   output logic                                   req_stall,
   input  wire logic [bfcf_pkg::UNITS_W-1:0]      req_frequency_units,
   // Result channel
   output logic                                   rsp_valid,
   input  wire logic                              rsp_stall,
   output logic [bfcf_pkg::BYTE_W-1:0]            rsp_command_byte,
   output logic                                   rsp_last_byte,
   // Configuration port
   input  wire logic                              csr_psel,
   input  wire logic                              csr_penable,
   input  wire logic                              csr_pwrite,
   input  wire logic [2:0]                        csr_paddr,
   input  wire logic [31:0]                       csr_pwdata,
   output logic [31:0]                            csr_prdata,
   output logic                                   csr_pready
);

   localparam int unsigned NUM_CELLS = bfcf_pkg::UNITS_W;

   bfcf_pkg::stage_type           chain [NUM_CELLS+1];
   logic                          advance;
   logic                          load;
   logic [bfcf_pkg::BYTE_W-1:0]   radio_addr_ff;
   logic [bfcf_pkg::BYTE_W-1:0]   ctrl_addr_ff;
   logic                          csr_write;
   logic                          csr_sel;

   // Configuration registers
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel & csr_penable & csr_pwrite;
   assign csr_sel    = csr_paddr[2];

   always_ff @(posedge clock) begin
      if (reset) begin
         radio_addr_ff <= bfcf_pkg::RADIO_ADDR_RST;
         ctrl_addr_ff  <= bfcf_pkg::CTRL_ADDR_RST;
      end else if (csr_write) begin
         unique case (csr_sel)
            bfcf_pkg::REG_RADIO_ADDR: radio_addr_ff <= csr_pwdata[7:0];
            bfcf_pkg::REG_CTRL_ADDR:  ctrl_addr_ff  <= csr_pwdata[7:0];
            default:                  radio_addr_ff <= radio_addr_ff;
         endcase
      end
   end

   always_comb begin
      unique case (csr_sel)
         bfcf_pkg::REG_RADIO_ADDR: csr_prdata = {24'd0, radio_addr_ff};
         bfcf_pkg::REG_CTRL_ADDR:  csr_prdata = {24'd0, ctrl_addr_ff};
         default:                  csr_prdata = 32'd0;
      endcase
   end

   // Freeze the chain while a finished word waits for the sequencer
   assign advance   = ~chain[NUM_CELLS].valid | load;
   assign req_stall = ~advance;

   // Saturate and feed the first cell
   assign chain[0].valid = req_valid;
   assign chain[0].bin   = (req_frequency_units > bfcf_pkg::MAX_UNITS) ?
                           bfcf_pkg::MAX_UNITS : req_frequency_units;
   assign chain[0].bcd   = '0;

   for (genvar g = 0; g < NUM_CELLS; g++) begin : g_cell
      bfcf_dd_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .advance  (advance),
         .slot_in  (chain[g]),
         .slot_out (chain[g+1])
      );
   end

   bfcf_framer u_framer (
      .clock            (clock),
      .reset            (reset),
      .tail             (chain[NUM_CELLS]),
      .radio_addr       (radio_addr_ff),
      .ctrl_addr        (ctrl_addr_ff),
      .load             (load),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_command_byte (rsp_command_byte),
      .rsp_last_byte    (rsp_last_byte)
   );

   // A finished conversion holds only decimal digits
   a_tail_digits : assert property (@(posedge clock) disable iff (reset)
      chain[NUM_CELLS].valid |-> bfcf_pkg::digits_ok(chain[NUM_CELLS].bcd))
      else $error("conversion chain produced a non-decimal digit");

   // A waiting conversion stays put until the sequencer loads it
   a_tail_hold : assert property (@(posedge clock) disable iff (reset)
      (chain[NUM_CELLS].valid && !load) |=>
         (chain[NUM_CELLS].valid && $stable(chain[NUM_CELLS].bcd)))
      else $error("waiting conversion lost or changed");

   // After the end byte is taken, the next byte shown opens a new frame
   a_frame_restart : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_stall && rsp_last_byte) |=>
         (!rsp_valid || (rsp_command_byte == bfcf_pkg::PREAMBLE_BYTE && !rsp_last_byte)))
      else $error("frame did not restart with the preamble");

   // The end byte is flagged and carries the end code
   a_last_is_end : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_last_byte) |-> (rsp_command_byte == bfcf_pkg::END_BYTE))
      else $error("last byte flag on a byte other than the end byte");

endmodule

`default_nettype wire
